/* rtl/fitl_pkg.sv */
// ----------------------------------------------------------------------------
// fitl_pkg
// Shared widths, constants, register indexes, sequencer states and the
// structs that pass between the frame interval trim blocks.
// ----------------------------------------------------------------------------
package fitl_pkg;

  // window storage
  localparam int WINDOW_DEPTH = 256;
  localparam int PTR_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int ITV_W        = 40;
  localparam int SUM_W        = ITV_W + PTR_W;

  // field widths
  localparam int TS_W       = 48;
  localparam int SNS_W      = 63;
  localparam int DUR_W      = 32;
  localparam int CD_W       = 7;
  localparam int WF_W       = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // microseconds to nanoseconds: 1000 = 1024 - 16 - 8
  localparam int US_TO_NS = 1000;
  localparam int US_SH_A  = 10;
  localparam int US_SH_B  = 4;
  localparam int US_SH_C  = 3;
  localparam logic [TS_W-1:0] SAT_US = TS_W'(((64'd1 << ITV_W) - 64'd1) / US_TO_NS);

  // correction law
  localparam int OFFSET_LIMIT    = 500000;
  localparam int OFFSET_DEADBAND = 50000;
  localparam int GAIN_SHIFT      = 6;
  localparam int STEP_W          = 20;
  localparam int DELTA_W         = STEP_W - GAIN_SHIFT;
  localparam int DIFF_W          = ITV_W + 2;
  localparam int ND_W            = DUR_W + 2;

  localparam logic [CD_W-1:0] FSC_MAX = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ADJUST_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEATING_MODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_INTERVAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DURATION    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DURATION    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_FRAMES = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_FRAMES   = 3'd6;

  // reset values
  localparam logic [DUR_W-1:0] RST_TARGET   = 32'd11111111;
  localparam logic [DUR_W-1:0] RST_MIN      = '0;
  localparam logic [DUR_W-1:0] RST_MAX      = '1;
  localparam logic [CD_W-1:0]  RST_COOLDOWN = 7'd8;
  localparam logic [WF_W-1:0]  RST_WINDOW   = 9'd32;

  // command codes
  localparam logic CMD_EVENT     = 1'b0;
  localparam logic CMD_FRAME_END = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EV_SCALE,
    ST_EV_SUB,
    ST_EV_ADD,
    ST_FE_DIV,
    ST_FE_STEP,
    ST_FE_SCALE,
    ST_FE_SUM,
    ST_FE_CLAMP,
    ST_REPLY
  } fitl_state_e;

  typedef struct packed {
    logic clear;
    logic sub_old;
    logic add_new;
  } ring_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] fill;
    logic             full;
    logic [SUM_W-1:0] sum;
  } ring_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // effective window length: zero reads as one, long windows saturate
  function automatic logic [CNT_W-1:0] win_len(input logic [WF_W-1:0] wf);
    logic [CNT_W-1:0] len;
    if (wf == '0) begin
      len = CNT_W'(1);
    end else if (int'(wf) > WINDOW_DEPTH) begin
      len = CNT_W'(WINDOW_DEPTH);
    end else begin
      len = CNT_W'(wf);
    end
    return len;
  endfunction

endpackage

/* rtl/fitl_in_if.sv */
// ----------------------------------------------------------------------------
// fitl_in_if
// Input word channel: completion events and frame ends.
// ----------------------------------------------------------------------------
interface fitl_in_if
  import fitl_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             command;
  logic [TS_W-1:0]  event_time_us;
  logic [SNS_W-1:0] sensor_time_ns;

  modport source (output valid, command, event_time_us, sensor_time_ns, input ready);
  modport sink   (input valid, command, event_time_us, sensor_time_ns, output ready);
endinterface

/* rtl/fitl_out_if.sv */
// ----------------------------------------------------------------------------
// fitl_out_if
// Result word channel: programmed duration and adjust flag.
// ----------------------------------------------------------------------------
interface fitl_out_if
  import fitl_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [DUR_W-1:0] duration_ns;
  logic             adjusted;

  modport source (output valid, duration_ns, adjusted, input ready);
  modport sink   (input valid, duration_ns, adjusted, output ready);
endinterface

/* rtl/fitl_div.sv */
// ----------------------------------------------------------------------------
// fitl_div
// Restoring divider, one quotient bit per cycle: window sum by fill count.
// ----------------------------------------------------------------------------
module fitl_div
  import fitl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output div_stat_t        stat_o,
  output logic [SUM_W-1:0] quotient_o
);

  localparam int ITER_W = $clog2(SUM_W + 1);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(SUM_W - 1);

  logic              busy_q, done_q;
  logic [ITER_W-1:0] cnt_q;
  logic [SUM_W-1:0]  quo_q;
  logic [CNT_W-1:0]  rem_q, dvs_q;
  logic [CNT_W:0]    trial;
  logic              fits;
  logic [CNT_W:0]    trial_sub;

  assign trial     = {rem_q, quo_q[SUM_W-1]};
  assign fits      = trial >= {1'b0, dvs_q};
  assign trial_sub = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + ITER_W'(1);
        if (cnt_q == ITER_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[SUM_W-2:0], fits};
      rem_q <= fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

/* rtl/fitl_ring.sv */
// ----------------------------------------------------------------------------
// fitl_ring
// Rolling interval window: ring memory, write pointer, fill count and sum.
// ----------------------------------------------------------------------------
module fitl_ring
  import fitl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ring_cmd_t        cmd_i,
  input  logic [CNT_W-1:0] win_len_i,
  input  logic [ITV_W-1:0] ns_i,
  output ring_stat_t       stat_o
);

  logic [ITV_W-1:0] mem [WINDOW_DEPTH];
  logic [ITV_W-1:0] rd_q;
  logic [PTR_W-1:0] ptr_q;
  logic [CNT_W-1:0] fill_q;
  logic [SUM_W-1:0] sum_q;
  logic             full;
  logic [CNT_W-1:0] ptr_inc;

  assign full    = fill_q >= win_len_i;
  assign ptr_inc = CNT_W'(ptr_q) + CNT_W'(1);

  // oldest entry sits under the write pointer; the pointer is idle before use
  always_ff @(posedge clk_i) begin
    rd_q <= mem[ptr_q];
    if (cmd_i.add_new) begin
      mem[ptr_q] <= ns_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else if (cmd_i.clear) begin
      ptr_q  <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else if (cmd_i.sub_old) begin
      if (full) begin
        sum_q <= sum_q - SUM_W'(rd_q);
      end
    end else if (cmd_i.add_new) begin
      sum_q <= sum_q + SUM_W'(ns_i);
      if (!full) begin
        fill_q <= fill_q + CNT_W'(1);
      end
      ptr_q <= (ptr_inc >= win_len_i) ? '0 : ptr_inc[PTR_W-1:0];
    end
  end

  assign stat_o.fill = fill_q;
  assign stat_o.full = full;
  assign stat_o.sum  = sum_q;

endmodule

/* rtl/frame_interval_trim_loop.sv */
// ----------------------------------------------------------------------------
// frame_interval_trim_loop
// Trim the programmed frame duration so measured capture intervals track a
// target interval, using a rolling window mean and a clamped, scaled step.
// ----------------------------------------------------------------------------
// Sequence: a completion event that enters the window passes the scale,
//   subtract and add steps before its reply; any other event and a frame
//   end that skips the mean go straight to the reply; a frame end that runs
//   the mean waits on the one-bit-a-cycle divider that forms sum / fill, then
//   runs the step, scale, sum and clamp steps. A result word held back by the sink holds the reply.
// Throughput: one word at a time; ready rises again as the result is loaded.
// Reset: control state clears, duration loads the reset target; the ring
//   memory is left unset and is only read where written since the last clear.
// ----------------------------------------------------------------------------
module frame_interval_trim_loop
  import fitl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  fitl_in_if.sink              in_i,
  fitl_out_if.source           out_o
);

  localparam logic signed [DIFF_W-1:0] LIM_POS  = DIFF_W'(OFFSET_LIMIT);
  localparam logic signed [DIFF_W-1:0] LIM_NEG  = -LIM_POS;
  localparam logic signed [STEP_W-1:0] BAND_POS = STEP_W'(OFFSET_DEADBAND);
  localparam logic signed [STEP_W-1:0] BAND_NEG = -BAND_POS;
  localparam logic signed [STEP_W-1:0] GAIN_RND = STEP_W'((1 << GAIN_SHIFT) - 1);

  // configuration registers
  logic             adjust_enable_q, repeating_mode_q;
  logic [DUR_W-1:0] target_q, min_q, max_q;
  logic [CD_W-1:0]  cooldown_q;
  logic [WF_W-1:0]  window_q;

  // loop state
  fitl_state_e      state_q, state_d;
  logic [TS_W-1:0]  last_ev_q;
  logic             ev_valid_q, sns_valid_q;
  logic [DUR_W-1:0] cur_dur_q;
  logic [CD_W-1:0]  fsc_q;

  // working registers
  logic [TS_W-1:0]          diff_q;
  logic [ITV_W-1:0]         ns_q;
  logic signed [STEP_W-1:0] step_q;
  logic                     apply_q;
  logic signed [DELTA_W-1:0] delta_q;
  logic signed [ND_W-1:0]   nd_q;
  logic                     adj_q;

  // result word register
  logic             out_valid_q;
  logic [DUR_W-1:0] out_dur_q;
  logic             out_adj_q;

  // sequencer controls
  logic       acc, fe_go, div_start, load_out;
  ring_cmd_t  ring_cmd;
  ring_stat_t ring_st;
  div_stat_t  div_st;

  logic [SUM_W-1:0]  quotient;
  logic [CNT_W-1:0]  win;
  logic [CD_W-1:0]   fsc_inc;
  logic              counting;

  // datapath terms
  logic [TS_W-1:0]          ev_diff;
  logic [ITV_W-1:0]         ns_calc;
  logic signed [DIFF_W-1:0] step_raw;
  logic signed [STEP_W-1:0] step_clip;
  logic signed [STEP_W-1:0] step_adj;
  logic signed [ND_W-1:0]   nd_lo;
  logic signed [ND_W-1:0]   min_ext, max_ext;
  logic [DUR_W-1:0]         nd_fin;

  assign win      = win_len(window_q);
  assign acc      = in_i.valid && in_i.ready;
  assign counting = adjust_enable_q && repeating_mode_q;
  assign fsc_inc  = (fsc_q == FSC_MAX) ? fsc_q : fsc_q + CD_W'(1);
  assign fe_go    = counting && (fsc_inc > cooldown_q) && sns_valid_q &&
                    ring_st.full && (ring_st.fill != '0);

  // ---- arithmetic ---------------------------------------------------------

  // backward timestamps count as zero
  assign ev_diff = (in_i.event_time_us >= last_ev_q) ?
                   in_i.event_time_us - last_ev_q : '0;

  // scale to ns with shifts, saturate where the product leaves 40 bits
  assign ns_calc = (diff_q > SAT_US) ? '1 :
                   ITV_W'((diff_q << US_SH_A) - (diff_q << US_SH_B) - (diff_q << US_SH_C));

  // step toward the target reduces to target minus mean
  assign step_raw = $signed({{(DIFF_W-DUR_W){1'b0}}, target_q}) -
                    $signed({{(DIFF_W-ITV_W){1'b0}}, quotient[ITV_W-1:0]});

  always_comb begin
    if (step_raw > LIM_POS) begin
      step_clip = STEP_W'(LIM_POS);
    end else if (step_raw < LIM_NEG) begin
      step_clip = STEP_W'(LIM_NEG);
    end else begin
      step_clip = STEP_W'(step_raw);
    end
  end

  // bias negative steps so the shift truncates toward zero
  assign step_adj = step_q + (step_q[STEP_W-1] ? GAIN_RND : STEP_W'(0));

  assign min_ext = $signed({2'b00, min_q});
  assign max_ext = $signed({2'b00, max_q});
  assign nd_lo   = (nd_q < min_ext) ? min_ext : nd_q;
  assign nd_fin  = (nd_lo > max_ext) ? max_q : nd_lo[DUR_W-1:0];

  // ---- sequencer: next state ---------------------------------------------

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (in_i.command == CMD_EVENT) begin
            state_d = (repeating_mode_q && ev_valid_q) ? ST_EV_SCALE : ST_REPLY;
          end else begin
            state_d = fe_go ? ST_FE_DIV : ST_REPLY;
          end
        end
      end
      ST_EV_SCALE: state_d = ST_EV_SUB;
      ST_EV_SUB:   state_d = ST_EV_ADD;
      ST_EV_ADD:   state_d = ST_REPLY;
      ST_FE_DIV: begin
        if (div_st.done) begin
          state_d = ST_FE_STEP;
        end
      end
      ST_FE_STEP:  state_d = ST_FE_SCALE;
      ST_FE_SCALE: state_d = ST_FE_SUM;
      ST_FE_SUM:   state_d = ST_FE_CLAMP;
      ST_FE_CLAMP: state_d = ST_REPLY;
      ST_REPLY: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---- sequencer: outputs ------------------------------------------------

  always_comb begin
    ring_cmd         = '0;
    div_start        = 1'b0;
    load_out         = 1'b0;
    ring_cmd.clear   = cfg_we_i && (cfg_idx_i == REG_WINDOW_FRAMES);
    case (state_q)
      ST_IDLE:   div_start = acc && (in_i.command == CMD_FRAME_END) && fe_go;
      ST_EV_SUB: ring_cmd.sub_old = 1'b1;
      ST_EV_ADD: ring_cmd.add_new = 1'b1;
      ST_REPLY:  load_out = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---- configuration -----------------------------------------------------

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adjust_enable_q  <= 1'b0;
      repeating_mode_q <= 1'b0;
      target_q         <= RST_TARGET;
      min_q            <= RST_MIN;
      max_q            <= RST_MAX;
      cooldown_q       <= RST_COOLDOWN;
      window_q         <= RST_WINDOW;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ADJUST_ENABLE:   adjust_enable_q  <= cfg_data_i[0];
        REG_REPEATING_MODE:  repeating_mode_q <= cfg_data_i[0];
        REG_TARGET_INTERVAL: target_q         <= cfg_data_i[DUR_W-1:0];
        REG_MIN_DURATION:    min_q            <= cfg_data_i[DUR_W-1:0];
        REG_MAX_DURATION:    max_q            <= cfg_data_i[DUR_W-1:0];
        REG_COOLDOWN_FRAMES: cooldown_q       <= cfg_data_i[CD_W-1:0];
        REG_WINDOW_FRAMES:   window_q         <= cfg_data_i[WF_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- loop state --------------------------------------------------------

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_ev_q   <= '0;
      ev_valid_q  <= 1'b0;
      sns_valid_q <= 1'b0;
      cur_dur_q   <= RST_TARGET;
      fsc_q       <= '0;
      adj_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        adj_q <= 1'b0;
        if (in_i.command == CMD_EVENT) begin
          // single shots drop the previous timestamp
          last_ev_q  <= repeating_mode_q ? in_i.event_time_us : '0;
          ev_valid_q <= repeating_mode_q;
        end else begin
          if (!repeating_mode_q) begin
            last_ev_q  <= '0;
            ev_valid_q <= 1'b0;
          end
          if (counting) begin
            fsc_q <= fsc_inc;
          end
          sns_valid_q <= 1'b1;
        end
      end
      if (state_q == ST_FE_CLAMP && apply_q) begin
        cur_dur_q <= nd_fin;
        fsc_q     <= '0;
        adj_q     <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers hold their value outside their own step
  always_ff @(posedge clk_i) begin
    if (acc) begin
      diff_q <= ev_diff;
    end
    if (state_q == ST_EV_SCALE) begin
      ns_q <= ns_calc;
    end
    if (state_q == ST_FE_STEP) begin
      step_q  <= step_clip;
      apply_q <= (step_clip > BAND_POS) || (step_clip < BAND_NEG);
    end
    if (state_q == ST_FE_SCALE) begin
      delta_q <= DELTA_W'(step_adj >>> GAIN_SHIFT);
    end
    if (state_q == ST_FE_SUM) begin
      nd_q <= $signed({2'b00, cur_dur_q}) + ND_W'(delta_q);
    end
    if (load_out) begin
      out_dur_q <= cur_dur_q;
      out_adj_q <= adj_q;
    end
  end

  // ---- units -------------------------------------------------------------

  fitl_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (ring_cmd),
    .win_len_i (win),
    .ns_i      (ns_q),
    .stat_o    (ring_st)
  );

  fitl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ring_st.sum),
    .divisor_i  (ring_st.fill),
    .stat_o     (div_st),
    .quotient_o (quotient)
  );

  // ---- ports -------------------------------------------------------------

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.duration_ns = out_dur_q;
  assign out_o.adjusted    = out_adj_q;

  // ---- assertions --------------------------------------------------------

  a_fill_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_st.fill <= win)
    else $error("window fill exceeds window length");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> (state_q == ST_FE_DIV))
    else $error("divider finished outside the mean wait step");

  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_st.busy)
    else $error("divider restarted while busy");

  a_adjust_in_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_adj_q && (min_q <= max_q)) |->
    ((out_dur_q >= min_q) && (out_dur_q <= max_q)))
    else $error("adjusted duration outside sensor limits");

endmodule
